>>> hdl/tsams_pkg.sv
// Package for the two-sorted-arrays middle-sum block.
// Holds the default store depth and the value widths; no dependencies.
package tsams_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int VAL_W     = 32;
    localparam int SUM_W     = VAL_W + 1;

endpackage

>>> hdl/two_sorted_arrays_middle_sum.sv
// Two-sorted-arrays middle-sum block: loads two sorted stores and selects the middle pair.
// Depends on tsams_pkg for the default depth and value widths.
//
// Input stream (s_axis): one element per item. tdata[31:0] is the signed value, tuser
// selects the store (0 first, 1 second), tlast closes the data set. Loading takes one
// item per cycle into synchronous memories; an element for a full store is discarded
// and the data set is flagged as having dropped elements.
// On the closing item drop tready and walk both memories with a halving rank
// selection: each narrowing step is a memory read (S_CHK), then a compare and
// narrow (S_CMP); a rank ends with a final read (S_CHK) and an add (S_FIN). An
// odd total needs one rank, an even total two; S_RES then moves the result to
// the output register.
// Output stream (m_axis): one item per data set: tdata[32:0] middle sum (the sum of
// the two middle elements, or the single middle one for an odd total), tuser[0]
// empty flag, tuser[1] dropped flag.
// The result waits in an output register while the next data set loads; if the
// receiver stalls, a finished walk holds until the register is free.
// Reset clears counts, flags, the state machine and the output valid; the memories
// are not cleared, since only entries written in the current data set are read.
module two_sorted_arrays_middle_sum #(
    parameter int DEPTH = tsams_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic [0:0]  i_s_axis_tuser,   // [0] mode
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [32:0] middle_sum, [39:33] zero
    output logic [1:0]  o_m_axis_tuser    // [0] empty_res, [1] dropped
);

    localparam int VW = tsams_pkg::VAL_W;
    localparam int SW = tsams_pkg::SUM_W;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = CW + 3;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CHK  = 5'b00010,
        S_CMP  = 5'b00100,
        S_FIN  = 5'b01000,
        S_RES  = 5'b10000
    } t_state;

    t_state r_state;

    // stores
    logic [VW-1:0] mem_a [DEPTH];
    logic [VW-1:0] mem_b [DEPTH];
    logic [VW-1:0] r_rd_a, r_rd_b;

    logic [CW-1:0] r_cnt_a, r_cnt_b;
    logic          r_drop;

    // walk registers
    logic signed [IW-1:0] r_alo, r_ahi, r_blo, r_bhi, r_k, r_ha, r_hb;
    logic [CW-1:0]        r_len_a, r_len_b;
    logic [CW:0]          r_half;
    logic                 r_two, r_ok_a, r_ok_b, r_fin_b;
    logic signed [SW-1:0] r_sum;
    logic                 r_res_empty, r_res_drop;

    // output register
    logic                 r_out_valid;
    logic [SW-1:0]        r_out_sum;
    logic                 r_out_empty, r_out_drop;

    logic          s_acc, full_a, full_b, wr_a, wr_b;
    logic [CW-1:0] n_cnt_a, n_cnt_b;
    logic          n_drop;
    logic [CW:0]   n_total;

    logic signed [IW-1:0] n_ha, n_hb, n_addr_a, n_addr_b, depth_s;
    logic                 n_a_empty, n_b_empty;
    logic [VW-1:0]        va, vb, vfin;
    logic                 a_gt_b;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign full_a  = (r_cnt_a == CW'(DEPTH));
    assign full_b  = (r_cnt_b == CW'(DEPTH));
    assign wr_a    = s_acc && !i_s_axis_tuser[0] && !full_a;
    assign wr_b    = s_acc &&  i_s_axis_tuser[0] && !full_b;
    assign n_cnt_a = wr_a ? r_cnt_a + CW'(1) : r_cnt_a;
    assign n_cnt_b = wr_b ? r_cnt_b + CW'(1) : r_cnt_b;
    assign n_drop  = r_drop || (s_acc && (i_s_axis_tuser[0] ? full_b : full_a));
    assign n_total = {1'b0, n_cnt_a} + {1'b0, n_cnt_b};

    assign depth_s   = $signed(IW'(DEPTH));
    assign n_a_empty = (r_alo > r_ahi);
    assign n_b_empty = (r_blo > r_bhi);
    assign n_ha      = (r_ahi - r_alo) >>> 1;
    assign n_hb      = (r_bhi - r_blo) >>> 1;

    // Read addresses: the end-of-walk read goes to the surviving store at lo + k.
    always_comb begin
        n_addr_a = r_alo + n_ha;
        n_addr_b = r_blo + n_hb;
        if (n_a_empty) begin
            n_addr_b = r_blo + r_k;
        end else if (n_b_empty) begin
            n_addr_a = r_alo + r_k;
        end
    end

    // Out-of-range reads return zero.
    assign va     = r_ok_a ? r_rd_a : '0;
    assign vb     = r_ok_b ? r_rd_b : '0;
    assign a_gt_b = ($signed(va) > $signed(vb));
    assign vfin   = r_fin_b ? vb : va;

    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            mem_a[r_cnt_a[AW-1:0]] <= i_s_axis_tdata;
        end
        r_rd_a <= mem_a[n_addr_a[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            mem_b[r_cnt_b[AW-1:0]] <= i_s_axis_tdata;
        end
        r_rd_b <= mem_b[n_addr_b[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // the result state reloads the output register itself
            if (r_out_valid && i_m_axis_tready && (r_state != S_RES)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        if (i_s_axis_tlast) begin
                            // latch the data set and clear counts for the next one
                            r_len_a     <= n_cnt_a;
                            r_len_b     <= n_cnt_b;
                            r_alo       <= '0;
                            r_blo       <= '0;
                            r_ahi       <= $signed(IW'(n_cnt_a)) - IW'(1);
                            r_bhi       <= $signed(IW'(n_cnt_b)) - IW'(1);
                            r_half      <= n_total >> 1;
                            r_two       <= !n_total[0];
                            r_k         <= n_total[0] ? $signed(IW'(n_total >> 1))
                                                      : $signed(IW'(n_total >> 1)) - IW'(1);
                            r_sum       <= '0;
                            r_res_empty <= (n_total == '0);
                            r_res_drop  <= n_drop;
                            r_cnt_a     <= '0;
                            r_cnt_b     <= '0;
                            r_drop      <= 1'b0;
                            r_state     <= (n_total == '0) ? S_RES : S_CHK;
                        end else begin
                            r_cnt_a <= n_cnt_a;
                            r_cnt_b <= n_cnt_b;
                            r_drop  <= n_drop;
                        end
                    end
                end
                S_CHK: begin
                    // issue the reads for this step
                    r_ok_a  <= (n_addr_a >= 0) && (n_addr_a < depth_s);
                    r_ok_b  <= (n_addr_b >= 0) && (n_addr_b < depth_s);
                    r_ha    <= n_ha;
                    r_hb    <= n_hb;
                    r_fin_b <= n_a_empty;
                    r_state <= (n_a_empty || n_b_empty) ? S_FIN : S_CMP;
                end
                S_CMP: begin
                    // narrow: drop the lower half of one store or the upper half of the other
                    if (r_ha + r_hb < r_k) begin
                        if (a_gt_b) begin
                            r_blo <= r_blo + r_hb + IW'(1);
                            r_k   <= r_k - r_hb - IW'(1);
                        end else begin
                            r_alo <= r_alo + r_ha + IW'(1);
                            r_k   <= r_k - r_ha - IW'(1);
                        end
                    end else begin
                        if (a_gt_b) begin
                            r_ahi <= r_alo + r_ha - IW'(1);
                        end else begin
                            r_bhi <= r_blo + r_hb - IW'(1);
                        end
                    end
                    r_state <= S_CHK;
                end
                S_FIN: begin
                    r_sum <= r_sum + $signed({vfin[VW-1], vfin});
                    if (r_two) begin
                        // even total: restart the walk for the upper middle rank
                        r_two   <= 1'b0;
                        r_k     <= $signed(IW'(r_half));
                        r_alo   <= '0;
                        r_blo   <= '0;
                        r_ahi   <= $signed(IW'(r_len_a)) - IW'(1);
                        r_bhi   <= $signed(IW'(r_len_b)) - IW'(1);
                        r_state <= S_CHK;
                    end else begin
                        r_state <= S_RES;
                    end
                end
                S_RES: begin
                    // hold until the output register is free
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_sum   <= r_sum;
                        r_out_empty <= r_res_empty;
                        r_out_drop  <= r_res_drop;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(40 - SW){1'b0}}, r_out_sum};
    assign o_m_axis_tuser  = {r_out_drop, r_out_empty};

endmodule
